// ===== sv/frs_pkg.sv =====
`default_nettype none

package frs_pkg;

   // record marker and result burst sizes
   localparam int MARKER_BYTES = 4;
   localparam int BURST_DEPTH  = 2 * MARKER_BYTES;
   localparam int BURST_CNT_W  = $clog2(BURST_DEPTH + 1);

   // mode register codes; bit 1 selects 8-byte markers
   localparam logic [1:0] MODE_SWAP    = 2'd0;
   localparam logic [1:0] MODE_UNSWAP  = 2'd1;
   localparam logic [1:0] MODE_UNSWAP8 = 2'd2;

   // request kinds
   localparam logic REQ_DATA = 1'b0;
   localparam logic REQ_END  = 1'b1;

   // result kinds
   localparam logic OUT_BYTE   = 1'b0;
   localparam logic OUT_STATUS = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_BAD_LENGTH,
      STATUS_MISMATCH,
      STATUS_TRUNCATED
   } status_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] in_byte;
   } req_payload_type;

   typedef struct packed {
      logic       out_kind;
      logic [7:0] out_byte;
      logic [1:0] status;
      logic       last;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ===== sv/frs_stream_if.sv =====
`default_nettype none

interface frs_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== sv/fortran_record_endian_swapper_top.sv =====
// Channel  | Dir | Payload                                  | Handshake
// ---------+-----+------------------------------------------+------------
// req_ch   | in  | req_type, in_byte                        | valid/ready
// rsp_ch   | out | out_kind, out_byte, status, last         | valid/ready
// csr_*    | in  | csr_wr_data (mode)                       | csr_wr_en
//
// One request transaction is taken per cycle. A payload byte pair leaves as two
// response transactions; a record marker leaves as a burst of 4 bytes (8 with
// 8-byte markers), one per cycle, so marker bursts set the rate at each record
// boundary. Requests that cause no response are taken even while a burst drains.
// Reset is synchronous and active high. A stalled rsp_ch holds the burst, and
// req_ch is held off while a burst is pending that would not finish this cycle.

`default_nettype none

module fortran_record_endian_swapper_top
   import frs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic [1:0] csr_wr_data,
   frs_stream_if.sink      req_ch,
   frs_stream_if.source    rsp_ch
);

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_PAYLOAD,
      PH_TRAILER,
      PH_STOPPED
   } phase_type;

   // control and record state
   logic [1:0]       mode_ff;
   phase_type        phase_ff, phase_in;
   logic [1:0]       mbc_ff, mbc_in;
   logic [31:0]      header_marker_ff, header_marker_in;
   logic             trailer_match_ff, trailer_match_in;
   logic [30:0]      payload_left_ff, payload_left_in;
   logic [7:0]       held_byte_ff, held_byte_in;

   // pending response burst
   logic [7:0]             burst_byte_ff [BURST_DEPTH];
   logic [7:0]             burst_byte_in [BURST_DEPTH];
   logic [BURST_CNT_W-1:0] burst_cnt_ff, burst_cnt_in;
   logic                   burst_kind_ff, burst_kind_in;
   status_type             burst_status_ff, burst_status_in;

   // step results
   logic [BURST_CNT_W-1:0] step_cnt;
   logic                   step_kind;
   status_type             step_status;
   logic                   step_marker;
   logic                   step_pair;

   req_payload_type req_pl;
   logic [7:0]      in_b;
   logic [31:0]     hm_wr;
   logic [31:0]     len;
   logic [30:0]     pl_dec;
   logic            tr_ok;
   logic            drained;
   logic            req_fire;
   logic            rsp_fire;

   assign req_pl = req_ch.payload;
   assign in_b   = req_pl.in_byte;

   // header with the incoming byte placed in its lane
   always_comb begin
      hm_wr = header_marker_ff;
      hm_wr[{mbc_ff, 3'b000} +: 8] = in_b;
   end

   // decode length in the input byte order
   assign len = (mode_ff == MODE_SWAP) ? hm_wr :
                {hm_wr[7:0], hm_wr[15:8], hm_wr[23:16], hm_wr[31:24]};

   assign pl_dec = payload_left_ff - 31'd1;
   assign tr_ok  = trailer_match_ff & (header_marker_ff[{mbc_ff, 3'b000} +: 8] == in_b);

   // advance the record state for one request
   always_comb begin
      phase_in         = phase_ff;
      mbc_in           = mbc_ff;
      header_marker_in = header_marker_ff;
      trailer_match_in = trailer_match_ff;
      payload_left_in  = payload_left_ff;
      held_byte_in     = held_byte_ff;
      step_cnt         = '0;
      step_kind        = OUT_BYTE;
      step_status      = STATUS_OK;
      step_marker      = 1'b0;
      step_pair        = 1'b0;

      if (phase_ff == PH_STOPPED) begin
         step_cnt = '0;
      end else if (req_pl.req_type == REQ_END) begin
         step_cnt  = BURST_CNT_W'(1);
         step_kind = OUT_STATUS;
         if (!(phase_ff == PH_HEADER && mbc_ff == 2'd0)) begin
            step_status = STATUS_TRUNCATED;
            phase_in    = PH_STOPPED;
         end
      end else begin
         case (phase_ff)
            PH_HEADER: begin
               header_marker_in = hm_wr;
               mbc_in           = mbc_ff + 2'd1;
               if (mbc_ff == 2'd3) begin
                  if (len[31] || len[0] || len == 32'd0) begin
                     step_cnt    = BURST_CNT_W'(1);
                     step_kind   = OUT_STATUS;
                     step_status = STATUS_BAD_LENGTH;
                     phase_in    = PH_STOPPED;
                  end else begin
                     step_marker     = 1'b1;
                     step_cnt        = mode_ff[1] ? BURST_CNT_W'(BURST_DEPTH)
                                                  : BURST_CNT_W'(MARKER_BYTES);
                     payload_left_in = len[30:0];
                     phase_in        = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               if (!payload_left_ff[0]) begin
                  held_byte_in = in_b;
               end else begin
                  step_pair = 1'b1;
                  step_cnt  = BURST_CNT_W'(2);
               end
               payload_left_in = pl_dec;
               if (pl_dec == 31'd0) begin
                  phase_in         = PH_TRAILER;
                  mbc_in           = 2'd0;
                  trailer_match_in = 1'b1;
               end
            end
            PH_TRAILER: begin
               trailer_match_in = tr_ok;
               mbc_in           = mbc_ff + 2'd1;
               if (mbc_ff == 2'd3) begin
                  trailer_match_in = 1'b1;
                  if (!tr_ok) begin
                     step_cnt    = BURST_CNT_W'(1);
                     step_kind   = OUT_STATUS;
                     step_status = STATUS_MISMATCH;
                     phase_in    = PH_STOPPED;
                  end else begin
                     step_marker = 1'b1;
                     step_cnt    = mode_ff[1] ? BURST_CNT_W'(BURST_DEPTH)
                                              : BURST_CNT_W'(MARKER_BYTES);
                     phase_in    = PH_HEADER;
                  end
               end
            end
            default: begin
               step_cnt = '0;
            end
         endcase
      end
   end

   // handshakes
   assign drained      = (burst_cnt_ff == '0) ||
                         (burst_cnt_ff == BURST_CNT_W'(1) && rsp_ch.ready);
   assign req_ch.ready = drained || (step_cnt == '0);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_fire     = rsp_ch.valid && rsp_ch.ready;

   // load a new burst or shift the pending one
   always_comb begin
      burst_cnt_in    = burst_cnt_ff;
      burst_kind_in   = burst_kind_ff;
      burst_status_in = burst_status_ff;
      for (int i = 0; i < BURST_DEPTH; i++) begin
         burst_byte_in[i] = burst_byte_ff[i];
      end
      if (req_fire && step_cnt != '0) begin
         burst_cnt_in    = step_cnt;
         burst_kind_in   = step_kind;
         burst_status_in = step_status;
         for (int i = 0; i < BURST_DEPTH; i++) begin
            burst_byte_in[i] = 8'h00;
         end
         if (step_marker) begin
            burst_byte_in[0] = header_marker_in[31:24];
            burst_byte_in[1] = header_marker_in[23:16];
            burst_byte_in[2] = header_marker_in[15:8];
            burst_byte_in[3] = header_marker_in[7:0];
         end else if (step_pair) begin
            burst_byte_in[0] = in_b;
            burst_byte_in[1] = held_byte_ff;
         end
      end else if (rsp_fire) begin
         burst_cnt_in = burst_cnt_ff - BURST_CNT_W'(1);
         for (int i = 0; i < BURST_DEPTH - 1; i++) begin
            burst_byte_in[i] = burst_byte_ff[i + 1];
         end
         burst_byte_in[BURST_DEPTH - 1] = 8'h00;
      end
   end

   // hold state and burst
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= MODE_SWAP;
         phase_ff         <= PH_HEADER;
         mbc_ff           <= 2'd0;
         header_marker_ff <= '0;
         trailer_match_ff <= 1'b1;
         payload_left_ff  <= '0;
         held_byte_ff     <= '0;
         burst_cnt_ff     <= '0;
         burst_kind_ff    <= OUT_BYTE;
         burst_status_ff  <= STATUS_OK;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         if (req_fire) begin
            phase_ff         <= phase_in;
            mbc_ff           <= mbc_in;
            header_marker_ff <= header_marker_in;
            trailer_match_ff <= trailer_match_in;
            payload_left_ff  <= payload_left_in;
            held_byte_ff     <= held_byte_in;
         end
         burst_cnt_ff    <= burst_cnt_in;
         burst_kind_ff   <= burst_kind_in;
         burst_status_ff <= burst_status_in;
      end
      for (int i = 0; i < BURST_DEPTH; i++) begin
         burst_byte_ff[i] <= burst_byte_in[i];
      end
   end

   // present the head of the burst
   assign rsp_ch.valid            = (burst_cnt_ff != '0);
   assign rsp_ch.payload.out_kind = burst_kind_ff;
   assign rsp_ch.payload.out_byte = burst_byte_ff[0];
   assign rsp_ch.payload.status   = burst_status_ff;
   assign rsp_ch.payload.last     = (burst_cnt_ff == BURST_CNT_W'(1));

endmodule

`default_nettype wire
